[src/ace_pkg.sv]
// ----------------------------------------------------------------------------
// ace_pkg: shared types and constants of the ARP cache engine
// Holds the command that is broadcast to the table cells, the link that
// travels from cell to cell, and the widths of the stream and config ports.
// ----------------------------------------------------------------------------
package ace_pkg;

  localparam int AceEntries = 16;

  localparam int InDataW  = 168;
  localparam int OutDataW = 136;
  localparam int OpcodeW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam int IpW  = 32;
  localparam int MacW = 48;
  localparam int ExpW = 17;

  typedef enum logic [1:0] {
    KindNone,
    KindLearn,
    KindLookup,
    KindSweep
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [IpW-1:0]    key_ip;
    logic [MacW-1:0]   mac;
    logic [ExpW-1:0]   expiry;
    logic [ExpW-1:0]   count;
  } cmd_t;

  typedef struct packed {
    logic            tok;
    logic            found;
    logic [MacW-1:0] mac;
  } link_t;

endpackage

[src/ace_cell.sv]
// ----------------------------------------------------------------------------
// ace_cell: one entry of the ARP table
// Holds one entry and acts on the broadcast command when the token arrives
// from its left neighbor, then hands token and search state to the right.
// ----------------------------------------------------------------------------
module ace_cell import ace_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  link_t lnk_i,
  output link_t lnk_o
);

  logic            valid_q, valid_d;
  logic [IpW-1:0]  ip_q;
  logic [MacW-1:0] mac_q;
  logic [ExpW-1:0] exp_q;
  link_t           lnk_q, lnk_d;

  logic ip_eq, act, learn_hit, look_hit, drop;

  always_comb begin
    ip_eq     = (ip_q == cmd_i.key_ip);
    act       = lnk_i.tok && !lnk_i.found;
    learn_hit = act && (cmd_i.kind == KindLearn) && (!valid_q || ip_eq);
    look_hit  = act && (cmd_i.kind == KindLookup) && valid_q && ip_eq;
    drop      = lnk_i.tok && (cmd_i.kind == KindSweep) && valid_q &&
                (exp_q != '0) && (cmd_i.count > exp_q);

    lnk_d = lnk_i;
    if (learn_hit) begin
      lnk_d.found = 1'b1;
    end
    if (look_hit) begin
      lnk_d.found = 1'b1;
      lnk_d.mac   = mac_q;
    end

    valid_d = valid_q;
    if (learn_hit) begin
      valid_d = 1'b1;
    end else if (drop) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lnk_q   <= '0;
    end else begin
      valid_q <= valid_d;
      lnk_q   <= lnk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (learn_hit) begin
      ip_q  <= cmd_i.key_ip;
      mac_q <= cmd_i.mac;
      exp_q <= cmd_i.expiry;
    end
  end

  assign lnk_o = lnk_q;

endmodule

[src/ace_ctrl.sv]
// ----------------------------------------------------------------------------
// ace_ctrl: item decode, tick counter, config registers and result register
// Decodes each input word into a table command, starts the token down the
// cell chain and packs the search outcome into the output word.
// ----------------------------------------------------------------------------
module ace_ctrl import ace_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [OpcodeW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cmd_t                cmd_o,
  output link_t               head_o,
  input  link_t               tail_i
);

  localparam logic [OpcodeW-1:0] OpPacket = 2'd0;
  localparam logic [OpcodeW-1:0] OpTick   = 2'd1;
  localparam logic [OpcodeW-1:0] OpLookup = 2'd2;

  localparam logic [15:0] ArpRequest = 16'd1;
  localparam logic [15:0] ArpReply   = 16'd2;

  localparam logic [CfgIdxW-1:0] RegLocalIp  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPeriod   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLifetime = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  state_e          state_q;
  logic [IpW-1:0]  local_ip_q;
  logic [15:0]     period_q;
  logic [15:0]     life_q;
  logic [15:0]     tick_q;
  cmd_t            cmd_q;
  link_t           head_q;
  logic            rsend_q;
  logic [IpW-1:0]  rip_q;
  logic [MacW-1:0] rmac_q;
  logic            hfound_q;
  logic [MacW-1:0] hmac_q;
  logic            m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  logic            frame_short;
  logic [15:0]     arp_op;
  logic [IpW-1:0]  sender_ip;
  logic [MacW-1:0] sender_mac;
  logic [IpW-1:0]  target_ip;
  logic [IpW-1:0]  lookup_ip;

  logic            accept, pkt_ok, is_req, is_rep, reply_d, learn_d, sweep_d;
  logic [ExpW-1:0] cnt_inc;
  cmd_t            cmd_d;
  logic            out_free, learned, hit, m_valid_d;
  logic [OutDataW-1:0] out_word;

  assign frame_short = s_axis_tdata[0];
  assign arp_op      = s_axis_tdata[16:1];
  assign sender_ip   = s_axis_tdata[48:17];
  assign sender_mac  = s_axis_tdata[96:49];
  assign target_ip   = s_axis_tdata[128:97];
  assign lookup_ip   = s_axis_tdata[160:129];

  always_comb begin
    accept  = s_axis_tvalid && (state_q == StIdle);
    pkt_ok  = (s_axis_tuser == OpPacket) && !frame_short;
    is_req  = (arp_op == ArpRequest);
    is_rep  = (arp_op == ArpReply);
    reply_d = pkt_ok && is_req && (target_ip == local_ip_q);
    learn_d = pkt_ok && (is_req || is_rep) && (sender_ip != '0);
    cnt_inc = {1'b0, tick_q} + 17'd1;
    sweep_d = (s_axis_tuser == OpTick) && (cnt_inc >= {1'b0, period_q});

    cmd_d.kind = KindNone;
    if (learn_d) begin
      cmd_d.kind = KindLearn;
    end else if (s_axis_tuser == OpLookup) begin
      cmd_d.kind = KindLookup;
    end else if (sweep_d) begin
      cmd_d.kind = KindSweep;
    end
    cmd_d.key_ip = (s_axis_tuser == OpLookup) ? lookup_ip : sender_ip;
    cmd_d.mac    = sender_mac;
    cmd_d.expiry = {1'b0, tick_q} + {1'b0, life_q};
    cmd_d.count  = cnt_inc;

    out_free  = !m_valid_q || m_axis_tready;
    m_valid_d = ((state_q == StDone) && out_free) || (m_valid_q && !m_axis_tready);
    learned   = (cmd_q.kind == KindLearn) && hfound_q;
    hit       = (cmd_q.kind == KindLookup) && hfound_q;
    out_word  = {5'd0, (hit ? hmac_q : {MacW{1'b0}}), hit, learned, rmac_q, rip_q, rsend_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      local_ip_q <= 32'd2130706433;
      period_q   <= 16'd1000;
      life_q     <= 16'd300;
      tick_q     <= '0;
      cmd_q      <= '0;
      head_q     <= '0;
      rsend_q    <= 1'b0;
      rip_q      <= '0;
      rmac_q     <= '0;
      hfound_q   <= 1'b0;
      hmac_q     <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      head_q    <= '{tok: accept, found: 1'b0, mac: '0};
      m_valid_q <= m_valid_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegLocalIp:  local_ip_q <= cfg_data_i;
          RegPeriod:   period_q   <= cfg_data_i[15:0];
          RegLifetime: life_q     <= cfg_data_i[15:0];
          default:     ;
        endcase
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            cmd_q   <= cmd_d;
            rsend_q <= reply_d;
            rip_q   <= reply_d ? sender_ip : '0;
            rmac_q  <= reply_d ? sender_mac : '0;
            if (s_axis_tuser == OpTick) begin
              tick_q <= sweep_d ? 16'd0 : cnt_inc[15:0];
            end
            state_q <= StRun;
          end
        end
        StRun: begin
          if (tail_i.tok) begin
            hfound_q <= tail_i.found;
            hmac_q   <= tail_i.mac;
            state_q  <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            m_data_q <= out_word;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cmd_o         = cmd_q;
  assign head_o        = head_q;

endmodule

[src/arp_cache_engine_unit.sv]
// ----------------------------------------------------------------------------
// arp_cache_engine_unit: ARP cache with aging, top level
// An accepted word sends the token from the head register through every cell register in turn;
// the token walks one cell per cycle, Run captures the chain end and Done writes the output register.
// The next word is taken only after Done, while a finished result may still wait on the output.
// Reset: table empty, tick count zero, config registers at their defaults.
// No clearing pass after reset; the block is ready in the first cycle.
// ----------------------------------------------------------------------------
module arp_cache_engine_unit import ace_pkg::*; #(
  parameter int ENTRIES = AceEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // frame_short, arp_op, sender_ip, sender_mac, target_ip, lookup_ip, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // opcode
  input  logic [OpcodeW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // reply_send, reply_ip, reply_mac, learned, lookup_hit, lookup_mac, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t               cmd;
  link_t              lnk [ENTRIES+1];
  logic [ENTRIES-1:0] tok_vec;

  ace_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_o         (cmd),
    .head_o        (lnk[0]),
    .tail_i        (lnk[ENTRIES])
  );

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ace_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .lnk_i  (lnk[g]),
      .lnk_o  (lnk[g+1])
    );
    assign tok_vec[g] = lnk[g+1].tok;
  end

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one token in the cell chain");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in progress");

  a_tail_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_vec[ENTRIES-1] |-> !s_axis_tready)
    else $error("token at chain end while the block is idle");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for arp_cache_engine_unit
// Drives packet, tick and lookup words through the input stream, predicts
// every result word with a cycle-free model of the cache and its aging, and
// compares the output stream field by field.  Directed tests cover the
// special cases; random phases vary the settings and the stream pressure.
// ----------------------------------------------------------------------------
module testbench;
  import ace_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 40;
  localparam int IpPool        = 24;
  localparam int MaxPrinted    = 30;

  typedef enum logic [1:0] {
    OpPacket = 2'd0,
    OpTick   = 2'd1,
    OpLookup = 2'd2,
    OpUnused = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    RegLocalIp     = 2'd0,
    RegSweepPeriod = 2'd1,
    RegLifetime    = 2'd2
  } reg_e;

  localparam logic [15:0] ArpRequest = 16'd1;
  localparam logic [15:0] ArpReply   = 16'd2;

  typedef struct packed {
    opcode_e         opcode;
    logic            frame_short;
    logic [15:0]     arp_op;
    logic [IpW-1:0]  sender_ip;
    logic [MacW-1:0] sender_mac;
    logic [IpW-1:0]  target_ip;
    logic [IpW-1:0]  lookup_ip;
  } arp_item_t;

  typedef struct packed {
    logic            reply_send;
    logic [IpW-1:0]  reply_ip;
    logic [MacW-1:0] reply_mac;
    logic            learned;
    logic            lookup_hit;
    logic [MacW-1:0] lookup_mac;
  } arp_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [OpcodeW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  logic            cache_valid  [AceEntries];
  logic [IpW-1:0]  cache_ip     [AceEntries];
  logic [MacW-1:0] cache_mac    [AceEntries];
  logic [ExpW-1:0] cache_expiry [AceEntries];
  logic [15:0]     tick_cnt;
  logic [IpW-1:0]  host_ip;
  logic [15:0]     sweep_at;
  logic [15:0]     life_ticks;

  arp_result_t    pending_results [$];
  logic [IpW-1:0] ip_pool [IpPool];

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int quiet_cycles    = 0;
  int mismatches      = 0;
  int words_sent      = 0;
  int results_seen    = 0;
  int replies         = 0;
  int learns          = 0;
  int hits            = 0;
  int sweeps          = 0;

  arp_cache_engine_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic arp_result_t resolve_arp(arp_item_t it);
    arp_result_t r;
    logic [16:0] count;
    r = '0;
    case (it.opcode)
      OpPacket: begin
        if (!it.frame_short) begin
          if (it.arp_op == ArpRequest && it.target_ip == host_ip) begin
            r.reply_send = 1'b1;
            r.reply_ip   = it.sender_ip;
            r.reply_mac  = it.sender_mac;
            replies++;
          end
          if ((it.arp_op == ArpRequest || it.arp_op == ArpReply) && it.sender_ip != '0) begin
            for (int i = 0; i < AceEntries; i++) begin
              if (!r.learned && (!cache_valid[i] || cache_ip[i] == it.sender_ip)) begin
                cache_valid[i]  = 1'b1;
                cache_ip[i]     = it.sender_ip;
                cache_mac[i]    = it.sender_mac;
                cache_expiry[i] = {1'b0, tick_cnt} + {1'b0, life_ticks};
                r.learned       = 1'b1;
              end
            end
            if (r.learned) learns++;
          end
        end
      end
      OpTick: begin
        count = {1'b0, tick_cnt} + 17'd1;
        if (count >= {1'b0, sweep_at}) begin
          for (int i = 0; i < AceEntries; i++) begin
            if (cache_valid[i] && cache_expiry[i] != '0 && count > cache_expiry[i]) begin
              cache_valid[i] = 1'b0;
            end
          end
          count = '0;
          sweeps++;
        end
        tick_cnt = count[15:0];
      end
      OpLookup: begin
        for (int i = 0; i < AceEntries; i++) begin
          if (!r.lookup_hit && cache_valid[i] && cache_ip[i] == it.lookup_ip) begin
            r.lookup_hit = 1'b1;
            r.lookup_mac = cache_mac[i];
          end
        end
        if (r.lookup_hit) hits++;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t: %s differs, got %h, expected %h", $time, what, got_v, want_v);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    arp_result_t got;
    arp_result_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no word moved for %0d cycles", WatchdogLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.reply_send = m_axis_tdata[0];
        got.reply_ip   = m_axis_tdata[32:1];
        got.reply_mac  = m_axis_tdata[80:33];
        got.learned    = m_axis_tdata[81];
        got.lookup_hit = m_axis_tdata[82];
        got.lookup_mac = m_axis_tdata[130:83];
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("word with nothing pending", m_axis_tdata[63:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (got.reply_send !== want.reply_send)
            report_mismatch("reply_send", 64'(got.reply_send), 64'(want.reply_send));
          if (got.reply_ip !== want.reply_ip)
            report_mismatch("reply_ip", 64'(got.reply_ip), 64'(want.reply_ip));
          if (got.reply_mac !== want.reply_mac)
            report_mismatch("reply_mac", 64'(got.reply_mac), 64'(want.reply_mac));
          if (got.learned !== want.learned)
            report_mismatch("learned", 64'(got.learned), 64'(want.learned));
          if (got.lookup_hit !== want.lookup_hit)
            report_mismatch("lookup_hit", 64'(got.lookup_hit), 64'(want.lookup_hit));
          if (got.lookup_mac !== want.lookup_mac)
            report_mismatch("lookup_mac", 64'(got.lookup_mac), 64'(want.lookup_mac));
        end
      end
    end
  end

  task automatic push_word(arp_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, it.lookup_ip, it.target_ip, it.sender_mac, it.sender_ip,
                      it.arp_op, it.frame_short};
    s_axis_tuser  <= it.opcode;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(resolve_arp(it));
    words_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_reg(reg_e idx, logic [CfgDataW-1:0] value);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegLocalIp:     host_ip    = value;
      RegSweepPeriod: sweep_at   = value[15:0];
      RegLifetime:    life_ticks = value[15:0];
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [31:0] ip, logic [15:0] period, logic [15:0] life);
    set_reg(RegLocalIp, ip);
    set_reg(RegSweepPeriod, {16'b0, period});
    set_reg(RegLifetime, {16'b0, life});
  endtask

  function automatic arp_item_t make_packet(logic short_f, logic [15:0] op,
                                            logic [IpW-1:0] sip, logic [MacW-1:0] smac,
                                            logic [IpW-1:0] tip);
    arp_item_t it;
    it             = '0;
    it.opcode      = OpPacket;
    it.frame_short = short_f;
    it.arp_op      = op;
    it.sender_ip   = sip;
    it.sender_mac  = smac;
    it.target_ip   = tip;
    return it;
  endfunction

  function automatic arp_item_t make_lookup(logic [IpW-1:0] ip);
    arp_item_t it;
    it           = '0;
    it.opcode    = OpLookup;
    it.lookup_ip = ip;
    return it;
  endfunction

  function automatic arp_item_t make_tick();
    arp_item_t it;
    it        = '0;
    it.opcode = OpTick;
    return it;
  endfunction

  function automatic logic [IpW-1:0] pick_ip();
    return ip_pool[$urandom_range(IpPool-1)];
  endfunction

  function automatic arp_item_t random_item();
    arp_item_t   it;
    logic [63:0] wide;
    int          roll;
    wide           = {$urandom, $urandom};
    it.opcode      = opcode_e'(2'($urandom_range(3)));
    it.frame_short = 1'($urandom_range(1));
    it.arp_op      = 16'($urandom);
    it.sender_ip   = $urandom;
    it.sender_mac  = wide[47:0];
    it.target_ip   = $urandom;
    it.lookup_ip   = $urandom;
    roll = $urandom_range(99);
    if (roll < 45) begin
      it.opcode      = OpPacket;
      it.frame_short = 1'b0;
      it.arp_op      = $urandom_range(1) ? ArpRequest : ArpReply;
      it.sender_ip   = pick_ip();
      if ($urandom_range(99) < 40) it.target_ip = host_ip;
    end else if (roll < 65) begin
      it.opcode = OpTick;
    end else if (roll < 88) begin
      it.opcode = OpLookup;
      if ($urandom_range(99) < 85) it.lookup_ip = pick_ip();
    end else if (roll < 94) begin
      it.opcode = OpPacket;
      it.arp_op = 16'($urandom_range(3));
      if ($urandom_range(1)) it.sender_ip = '0;
      if ($urandom_range(1)) it.target_ip = host_ip;
    end
    return it;
  endfunction

  task automatic test_directed();
    arp_item_t it;
    push_word(make_tick());
    push_word(make_packet(1'b0, ArpRequest, 32'h0A00_0001, 48'h0200_0000_0001, host_ip));
    push_word(make_packet(1'b0, ArpRequest, 32'h0A00_0002, 48'h0200_0000_0002, 32'h0A00_00FE));
    push_word(make_packet(1'b0, ArpReply, 32'h0A00_0003, 48'h0200_0000_0003, 32'h0A00_0001));
    push_word(make_packet(1'b0, 16'h0000, 32'h0A00_0004, 48'h0200_0000_0004, host_ip));
    it = make_packet(1'b0, 16'hFFFF, '1, '1, '1);
    it.lookup_ip = '1;
    push_word(it);
    push_word(make_packet(1'b0, ArpRequest, '0, 48'h0200_0000_0007, host_ip));
    push_word(make_packet(1'b1, ArpRequest, 32'h0A00_0008, 48'h0200_0000_0008, host_ip));
    it = make_packet(1'b0, ArpRequest, 32'h0A00_0009, 48'h0200_0000_0009, host_ip);
    it.opcode = OpUnused;
    push_word(it);
    it = make_packet(1'b1, '1, '1, '1, '1);
    it.lookup_ip = '1;
    it.opcode    = OpTick;
    push_word(it);
    push_word(make_lookup(32'h0A00_0001));
    push_word(make_lookup(32'h0A00_0004));
    push_word(make_lookup('0));
    push_word(make_packet(1'b0, ArpReply, 32'h0A00_0001, 48'hFFFF_0000_FFFF, '0));
    push_word(make_lookup(32'h0A00_0001));
    push_word(make_packet(1'b0, ArpRequest, '1, '1, host_ip));
    push_word(make_lookup('1));
    push_word(make_packet(1'b0, ArpReply, 32'h0A00_000A, '0, '0));
    push_word(make_lookup(32'h0A00_000A));
    set_reg(RegLocalIp, '1);
    push_word(make_packet(1'b0, ArpRequest, 32'h0A00_000B, 48'h0200_0000_000B, '1));
    push_word(make_packet(1'b0, ArpRequest, 32'h0A00_000C, 48'h0200_0000_000C, 32'h7F00_0001));
    set_reg(RegLocalIp, '0);
    push_word(make_packet(1'b0, ArpRequest, 32'h0A00_000D, 48'h0200_0000_000D, '0));
    set_reg(RegLocalIp, 32'h7F00_0001);
  endtask

  task automatic test_table_full();
    for (int i = 1; i <= AceEntries + 1; i++) begin
      push_word(make_packet(1'b0, (i % 2) ? ArpRequest : ArpReply, 32'hC0A8_0100 + i,
                            {16'hAC00, 32'(i)}, 32'h0A00_00FE));
    end
    push_word(make_packet(1'b0, ArpReply, 32'h0A00_0002, 48'h0200_00AA_0002, '0));
    push_word(make_lookup(32'h0A00_0002));
    push_word(make_lookup(32'hC0A8_0100 + AceEntries + 1));
    push_word(make_lookup(32'hC0A8_0101));
  endtask

  task automatic test_aging();
    logic            snap_valid [AceEntries];
    logic [IpW-1:0]  snap_ip    [AceEntries];
    logic [MacW-1:0] snap_mac   [AceEntries];
    logic [IpW-1:0]  keep_ip;
    logic [IpW-1:0]  drop_ip;
    keep_ip = 32'h0A0A_0A01;
    drop_ip = 32'h0A0A_0A02;
    // With a zero period every tick sweeps and clears the count.
    set_reg(RegSweepPeriod, '0);
    set_reg(RegLifetime, 32'd1);
    push_word(make_tick());
    for (int i = 0; i < AceEntries; i++) begin
      snap_valid[i] = cache_valid[i];
      snap_ip[i]    = cache_ip[i];
      snap_mac[i]   = cache_mac[i];
    end
    for (int i = 0; i < AceEntries; i++) begin
      if (snap_valid[i]) push_word(make_packet(1'b0, ArpReply, snap_ip[i], snap_mac[i], '0));
    end
    set_reg(RegSweepPeriod, 32'd3);
    repeat (3) push_word(make_tick());
    push_word(make_lookup(snap_ip[0]));
    push_word(make_lookup(snap_ip[AceEntries-1]));
    set_reg(RegSweepPeriod, 32'd20);
    set_reg(RegLifetime, 32'd0);
    push_word(make_packet(1'b0, ArpRequest, keep_ip, 48'h0200_0A0A_0A01, host_ip));
    set_reg(RegLifetime, 32'd2);
    push_word(make_packet(1'b0, ArpReply, drop_ip, 48'h0200_0A0A_0A02, '0));
    repeat (6) push_word(make_tick());
    // A period below the running count makes the next tick sweep.
    set_reg(RegSweepPeriod, 32'd4);
    push_word(make_tick());
    push_word(make_lookup(keep_ip));
    push_word(make_lookup(drop_ip));
  endtask

  task automatic run_phase(int words, int idle_pct, int stall_pct, logic [31:0] ip,
                           logic [15:0] period, logic [15:0] life);
    apply_settings(ip, period, life);
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    repeat (words) push_word(random_item());
  endtask

  task automatic test_random();
    logic [IpW-1:0] ip;
    for (int i = 0; i < IpPool; i++) begin
      do ip = $urandom; while (ip == '0);
      ip_pool[i] = ip;
    end
    run_phase(240, 0, 0, $urandom, 16'd6, 16'd1);
    run_phase(240, 80, 0, 32'hFFFF_FFFF, 16'd1, 16'd2);
    run_phase(240, 0, 80, 32'h0000_0000, 16'd10, 16'd3);
    run_phase(240, 30, 30, $urandom, 16'hFFFF, 16'hFFFF);
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
  endtask

  initial begin
    for (int i = 0; i < AceEntries; i++) cache_valid[i] = 1'b0;
    tick_cnt   = '0;
    host_ip    = 32'h7F00_0001;
    sweep_at   = 16'd1000;
    life_ticks = 16'd300;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_aging();
    test_random();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d words: %0d replies, %0d senders learned, %0d lookup hits, %0d sweeps.",
             words_sent, replies, learns, hits, sweeps);
    $display("Checked %0d result words over four stream pressure phases, %0d field errors.",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[arp_cache_engine_unit.f]
src/ace_pkg.sv
src/ace_cell.sv
src/ace_ctrl.sv
src/arp_cache_engine_unit.sv
tb/testbench.sv
